[hw/rtl/bta_pkg.sv]
// Package for the bakery ticket arbiter: item types, codes and defaults.
`timescale 1ns / 1ps
package bta_pkg;

    // Default sizes of the ticket store
    localparam int BTA_MAX_REQUESTERS = 8;
    localparam int BTA_TICKET_BITS    = 16;

    // Fixed field widths of the items
    localparam int ID_W     = 3;
    localparam int COUNT_W  = 4;
    localparam int ASSIGN_W = 16;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Reset value of the requester count register
    localparam logic [COUNT_W-1:0] ACTIVE_COUNT_RESET = 4'd8;

    // Register index, taken from paddr[2]
    localparam logic REG_ACTIVE_COUNT = 1'b0;

    // Item kinds
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_WAITING   = 2'd2,
        ST_SATURATED = 2'd3
    } status_t;

    typedef struct packed {
        logic            kind;
        logic [ID_W-1:0] requester_id;
    } in_item_t;

    typedef struct packed {
        logic                holder_valid;
        logic [ID_W-1:0]     holder_id;
        logic [ASSIGN_W-1:0] assigned_ticket;
        status_t             status;
    } out_item_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SCAN   = 2'd1,
        S_FINISH = 2'd2
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_busy;
    } dp_status_t;

endpackage

[hw/rtl/bta_ctrl.sv]
// Controller state machine for the bakery ticket arbiter.
`timescale 1ns / 1ps
module bta_ctrl
    import bta_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  dp_status_t dp_status,
    output ctrl_cmd_t  ctrl_cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence load, scan and commit of one item
    always_comb
    begin
        state_next      = state_reg;
        cmd_ready       = 1'b0;
        ctrl_cmd.load   = 1'b0;
        ctrl_cmd.step   = 1'b0;
        ctrl_cmd.commit = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    ctrl_cmd.load = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctrl_cmd.step = 1'b1;
                if (dp_status.scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // wait for the output register to free up
                if (!dp_status.out_busy)
                begin
                    ctrl_cmd.commit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/bta_dp.sv]
// Datapath for the bakery ticket arbiter: ticket store, scan and result register.
`timescale 1ns / 1ps
module bta_dp
    import bta_pkg::*;
#(
    parameter int MAX_REQUESTERS = BTA_MAX_REQUESTERS,
    parameter int TICKET_BITS    = BTA_TICKET_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          ctrl_cmd,
    output dp_status_t         dp_status,
    input  in_item_t           cmd_item,
    input  logic [COUNT_W-1:0] active_count,
    output logic               res_valid,
    input  logic               res_ready,
    output out_item_t          res_item
);

    localparam int KW    = $clog2(MAX_REQUESTERS);
    localparam int CW    = $clog2(MAX_REQUESTERS + 1);
    localparam int CMP_W = (CW > ID_W) ? CW : ID_W;
    localparam int AC_W  = (CW > COUNT_W) ? CW : COUNT_W;
    localparam logic [TICKET_BITS-1:0] TICKET_MAX = {TICKET_BITS{1'b1}};
    localparam logic [KW-1:0]          LAST_IDX   = KW'(MAX_REQUESTERS - 1);

    logic [TICKET_BITS-1:0] tickets_reg [MAX_REQUESTERS];
    logic                   kind_reg;
    logic [ID_W-1:0]        id_reg;
    logic [CW-1:0]          n_reg;
    logic [KW-1:0]          idx_reg;
    logic [TICKET_BITS-1:0] max_reg;
    logic [TICKET_BITS-1:0] own_reg;
    logic                   have_reg;
    logic [KW-1:0]          hid_reg;
    logic [TICKET_BITS-1:0] hmin_reg;
    out_item_t              out_item_reg;
    logic                   out_valid_reg;

    logic [CW-1:0]          eff_count;
    logic [TICKET_BITS-1:0] scan_t;
    logic                   scan_in;
    logic                   scan_own;
    logic                   id_in;
    logic                   write_en;
    logic [TICKET_BITS-1:0] new_t;
    status_t                fin_status;
    logic [TICKET_BITS-1:0] fin_assigned;
    logic                   fin_have;
    logic [ID_W-1:0]        fin_hid;

    // Clamp the configured count into 1..MAX_REQUESTERS
    always_comb
    begin
        if (active_count == '0)
        begin
            eff_count = CW'(1);
        end
        else if (AC_W'(active_count) > AC_W'(MAX_REQUESTERS))
        begin
            eff_count = CW'(MAX_REQUESTERS);
        end
        else
        begin
            eff_count = CW'(active_count);
        end
    end

    // Look at one stored ticket per cycle
    assign scan_t    = tickets_reg[idx_reg];
    assign scan_in   = CMP_W'(idx_reg) < CMP_W'(n_reg);
    assign scan_own  = CMP_W'(idx_reg) == CMP_W'(id_reg);
    assign id_in     = CMP_W'(id_reg) < CMP_W'(n_reg);

    assign dp_status.scan_done = (idx_reg == LAST_IDX);
    assign dp_status.out_busy  = out_valid_reg && !res_ready;

    // Work out the update and the new holder
    always_comb
    begin
        write_en     = 1'b0;
        new_t        = '0;
        fin_status   = ST_OK;
        fin_assigned = '0;
        if (!id_in)
        begin
            fin_status = ST_RANGE;
        end
        else if (kind_reg == KIND_RELEASE)
        begin
            write_en = 1'b1;
        end
        else if (own_reg != '0)
        begin
            fin_status = ST_WAITING;
            new_t      = own_reg;
        end
        else if (max_reg == TICKET_MAX)
        begin
            write_en     = 1'b1;
            new_t        = TICKET_MAX;
            fin_assigned = TICKET_MAX;
            fin_status   = ST_SATURATED;
        end
        else
        begin
            write_en     = 1'b1;
            new_t        = max_reg + 1'b1;
            fin_assigned = new_t;
        end

        // the requester's own entry was left out of the holder search during the scan
        fin_have = have_reg;
        fin_hid  = ID_W'(hid_reg);
        if (id_in && (new_t != '0) &&
            (!have_reg || (new_t < hmin_reg) ||
             ((new_t == hmin_reg) && (CMP_W'(id_reg) < CMP_W'(hid_reg)))))
        begin
            fin_have = 1'b1;
            fin_hid  = id_reg;
        end
    end

    // Latch the item and run the scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (ctrl_cmd.load)
        begin
            idx_reg <= '0;
        end
        else if (ctrl_cmd.step)
        begin
            idx_reg <= dp_status.scan_done ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.load)
        begin
            kind_reg <= cmd_item.kind;
            id_reg   <= cmd_item.requester_id;
            n_reg    <= eff_count;
            max_reg  <= '0;
            own_reg  <= '0;
            have_reg <= 1'b0;
            hid_reg  <= '0;
            hmin_reg <= '0;
        end
        else if (ctrl_cmd.step && scan_in)
        begin
            if (scan_t > max_reg)
            begin
                max_reg <= scan_t;
            end
            if (scan_own)
            begin
                own_reg <= scan_t;
            end
            if (!(scan_own && id_in) && (scan_t != '0) && (!have_reg || (scan_t < hmin_reg)))
            begin
                have_reg <= 1'b1;
                hid_reg  <= idx_reg;
                hmin_reg <= scan_t;
            end
        end
    end

    // Update the ticket store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_REQUESTERS; k++)
            begin
                tickets_reg[k] <= '0;
            end
        end
        else if (ctrl_cmd.commit && write_en)
        begin
            for (int k = 0; k < MAX_REQUESTERS; k++)
            begin
                if (CMP_W'(k) == CMP_W'(id_reg))
                begin
                    tickets_reg[k] <= new_t;
                end
            end
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl_cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.commit)
        begin
            out_item_reg.holder_valid    <= fin_have;
            out_item_reg.holder_id       <= fin_hid;
            out_item_reg.assigned_ticket <= ASSIGN_W'(fin_assigned);
            out_item_reg.status          <= fin_status;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_item  = out_item_reg;

`ifndef NO_ASSERTIONS
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.commit |-> !(out_valid_reg && !res_ready))
        else $error("result committed over an untaken item");

    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.commit |=> out_valid_reg)
        else $error("committed result not shown");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_item_reg.status == ST_RANGE)) |->
            (out_item_reg.assigned_ticket == '0))
        else $error("rejected item carries a ticket");

    a_no_holder_id: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_item_reg.holder_valid) |-> (out_item_reg.holder_id == '0))
        else $error("holder id set without a holder");
`endif

endmodule

[hw/rtl/bakery_ticket_arbiter.sv]
// Top level of the bakery ticket arbiter: configuration register and block wiring.
`timescale 1ns / 1ps
// Mutual-exclusion lock on bakery tickets. Each item on the cmd channel is a
// request or a release from one requester; each produces exactly one item on
// the res channel with the current holder (smallest nonzero ticket, lower
// index on ties), the ticket assigned and a status. After the item is
// accepted, the scan looks at one ticket entry per cycle to find the
// largest ticket and the current holder, then the update is committed into
// the result register. The next item is taken in the cycle after the
// commit. A finished result waits in that register while the next item
// is taken; the commit of that next item stalls until the earlier result
// has been taken. The requester count register sits at byte address 0 and
// may be written only while the block is idle.
module bakery_ticket_arbiter
    import bta_pkg::*;
#(
    parameter int MAX_REQUESTERS = BTA_MAX_REQUESTERS,
    parameter int TICKET_BITS    = BTA_TICKET_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  in_item_t           cmd_item,
    output logic               res_valid,
    input  logic               res_ready,
    output out_item_t          res_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [COUNT_W-1:0] active_count_reg;
    ctrl_cmd_t          ctrl_cmd;
    dp_status_t         dp_status;

    // Write the requester count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_count_reg <= ACTIVE_COUNT_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_ACTIVE_COUNT))
        begin
            active_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // Read back and never stall
    assign prdata = (paddr[2] == REG_ACTIVE_COUNT) ? PDATA_W'(active_count_reg) : '0;
    assign pready = 1'b1;

    bta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .dp_status (dp_status),
        .ctrl_cmd  (ctrl_cmd)
    );

    bta_dp #(
        .MAX_REQUESTERS (MAX_REQUESTERS),
        .TICKET_BITS    (TICKET_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl_cmd     (ctrl_cmd),
        .dp_status    (dp_status),
        .cmd_item     (cmd_item),
        .active_count (active_count_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res_item     (res_item)
    );

endmodule
